[rtl/core/mcic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcic_pkg: shared types and constants for the interval cover block
// Position and cost widths, tree geometry, register indexes and states.
// ----------------------------------------------------------------------------
package mcic_pkg;

  localparam int unsigned PosBits    = 15;
  localparam int unsigned Positions  = 1 << PosBits;
  localparam int unsigned TreeDepth  = 2 * Positions;
  localparam int unsigned TreeAw     = PosBits + 1;
  // query bounds run one past the last leaf
  localparam int unsigned IdxBits    = PosBits + 2;
  localparam int unsigned CostBits   = 48;
  localparam int unsigned InCostBits = 20;
  localparam int unsigned SumBits    = CostBits + 1;
  localparam int unsigned OutBits    = 48;
  localparam int unsigned CfgIdxBits = 1;

  localparam logic [CostBits-1:0] Inf = {CostBits{1'b1}};

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStart = 1'b0,
    CfgEnd   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLeft,
    StRight,
    StAdd,
    StUpd,
    StOut
  } state_e;

  function automatic logic [CostBits-1:0] cost_min(input logic [CostBits-1:0] a,
                                                   input logic [CostBits-1:0] b);
    cost_min = (a < b) ? a : b;
  endfunction

endpackage

[rtl/core/mcic_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcic_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/min_cost_interval_cover.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_cost_interval_cover: weighted interval cover over a min segment tree
// Keeps the best cover cost per compressed position in a range-minimum tree
// held in one RAM, and reports the best cost at the span end per interval.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive left_index_i, right_index_i, interval_cost_i and pulse
//   start_i; the word is taken on a clock edge where start_i is high and
//   busy_o is low. Intervals arrive sorted by right end.
//   Output: one result word per interval, shown for a single cycle with
//   result_valid_o high; best_cost_o is all ones and found_o low while no
//   chosen set covers the span. The receiver cannot stall the block.
//   Config: start and end positions go in via cfg_valid_i / cfg_ready_o
//   (always ready). User rule, unchecked: write only while busy_o is low.
//   Sequence: the range query (skipped if left_index_i <= the start
//   position) walks the tree level by level through the single RAM read
//   port; then the saturating add, a read-modify-write up the leaf-to-root
//   path and the result state. busy_o falls after the result.
//   Reset: the tree is swept to infinity one entry per cycle, over all its
//   entries, with busy_o high; configuration writes are still taken then.
// ----------------------------------------------------------------------------
module min_cost_interval_cover (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [mcic_pkg::PosBits-1:0]       left_index_i,
  input  logic [mcic_pkg::PosBits-1:0]       right_index_i,
  input  logic [mcic_pkg::InCostBits-1:0]    interval_cost_i,
  output logic                               result_valid_o,
  output logic [mcic_pkg::OutBits-1:0]       best_cost_o,
  output logic                               found_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mcic_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [mcic_pkg::PosBits-1:0]       cfg_data_i
);

  mcic_pkg::state_e                  state_q, state_d;
  logic [mcic_pkg::PosBits-1:0]      start_pos_q, end_pos_q;
  logic [mcic_pkg::TreeAw-1:0]       clr_q, clr_d;
  logic [mcic_pkg::IdxBits-1:0]      l_q, l_d, r_q, r_d;
  logic [mcic_pkg::CostBits-1:0]     best_q, best_d;
  logic [mcic_pkg::CostBits-1:0]     total_q, total_d;
  logic                              rd_pend_q, rd_pend_d;
  logic [mcic_pkg::TreeAw-1:0]       node_q, node_d;
  logic [mcic_pkg::PosBits-1:0]      right_q, right_d;
  logic [mcic_pkg::InCostBits-1:0]   cost_q, cost_d;
  logic [mcic_pkg::SumBits-1:0]      sum;

  logic                              ram_we;
  logic [mcic_pkg::TreeAw-1:0]       ram_waddr, ram_raddr;
  logic [mcic_pkg::CostBits-1:0]     ram_wdata, rd_data;

  mcic_ram #(
    .Width (mcic_pkg::CostBits),
    .Depth (mcic_pkg::TreeDepth)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
      end_pos_q   <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mcic_pkg::cfg_reg_e'(cfg_index_i))
        mcic_pkg::CfgStart: start_pos_q <= cfg_data_i;
        mcic_pkg::CfgEnd:   end_pos_q   <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mcic_pkg::StClear;
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    r_q     <= r_d;
    best_q  <= best_d;
    total_q <= total_d;
    node_q  <= node_d;
    right_q <= right_d;
    cost_q  <= cost_d;
  end

  assign sum = {1'b0, best_q} + mcic_pkg::SumBits'(cost_q);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    l_d       = l_q;
    r_d       = r_q;
    // fold in the tree word read last cycle
    best_d    = rd_pend_q ? mcic_pkg::cost_min(best_q, rd_data) : best_q;
    total_d   = total_q;
    rd_pend_d = 1'b0;
    node_d    = node_q;
    right_d   = right_q;
    cost_d    = cost_q;
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = mcic_pkg::cost_min(rd_data, total_q);
    ram_raddr = '0;

    unique case (state_q)
      mcic_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = mcic_pkg::Inf;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = mcic_pkg::StIdle;
        end
      end
      mcic_pkg::StIdle: begin
        if (start_i) begin
          right_d = right_index_i;
          cost_d  = interval_cost_i;
          if (left_index_i <= start_pos_q) begin
            best_d  = '0;
            state_d = mcic_pkg::StAdd;
          end else begin
            best_d  = mcic_pkg::Inf;
            l_d     = {2'b01, left_index_i - 1'b1};
            r_d     = {2'b01, right_index_i} + 1'b1;
            state_d = mcic_pkg::StLeft;
          end
        end
      end
      mcic_pkg::StLeft: begin
        if (l_q >= r_q) begin
          state_d = mcic_pkg::StAdd;
        end else begin
          if (l_q[0]) begin
            ram_raddr = l_q[mcic_pkg::TreeAw-1:0];
            rd_pend_d = 1'b1;
            l_d       = l_q + 1'b1;
          end
          state_d = mcic_pkg::StRight;
        end
      end
      mcic_pkg::StRight: begin
        if (r_q[0]) begin
          ram_raddr = {r_q[mcic_pkg::TreeAw-1:1], 1'b0};
          rd_pend_d = 1'b1;
        end
        // climb one level
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = mcic_pkg::StLeft;
      end
      mcic_pkg::StAdd: begin
        total_d   = (sum >= {1'b0, mcic_pkg::Inf}) ? mcic_pkg::Inf
                                                   : sum[mcic_pkg::CostBits-1:0];
        ram_raddr = {1'b1, right_q};
        node_d    = {1'b1, right_q};
        state_d   = mcic_pkg::StUpd;
      end
      mcic_pkg::StUpd: begin
        // merge into this node, fetch its parent (the end leaf at the root)
        ram_we = 1'b1;
        if (node_q == mcic_pkg::TreeAw'(1)) begin
          ram_raddr = {1'b1, end_pos_q};
          state_d   = mcic_pkg::StOut;
        end else begin
          ram_raddr = node_q >> 1;
          node_d    = node_q >> 1;
        end
      end
      mcic_pkg::StOut: begin
        state_d = mcic_pkg::StIdle;
      end
      default: begin
        state_d = mcic_pkg::StIdle;
      end
    endcase
  end

  assign busy_o         = (state_q != mcic_pkg::StIdle);
  assign result_valid_o = (state_q == mcic_pkg::StOut);
  assign best_cost_o    = mcic_pkg::OutBits'(rd_data);
  assign found_o        = (rd_data != mcic_pkg::Inf);

  a_out_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == mcic_pkg::StUpd && node_q == mcic_pkg::TreeAw'(1)))
    else $error("result shown without finishing the root update");

  a_add_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcic_pkg::StAdd |-> !rd_pend_q)
    else $error("query read still pending at the add");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == mcic_pkg::StClear || state_q == mcic_pkg::StUpd))
    else $error("tree written outside clear or update");

  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !result_valid_o)
    else $error("result in the cycle after an accept");

  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcic_pkg::StUpd |-> node_q != '0)
    else $error("update walked past the root");

endmodule
